// ===== hdl/chl_pkg.sv =====
// Shared types and constants for the C source highlight lexer.
// Used by chl_front, chl_queue, chl_back and the top level; depends on nothing.
package chl_pkg;

    localparam int KEYWORD_LEN = 5;
    localparam int KW_W        = 40;
    localparam int WORD_W      = 8 * KEYWORD_LEN;
    localparam int CMP_W       = (WORD_W > KW_W) ? WORD_W : KW_W;
    localparam int CNT_W       = $clog2(KEYWORD_LEN + 1);
    localparam int IDX_W       = (KEYWORD_LEN > 1) ? $clog2(KEYWORD_LEN) : 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int NUM_KW      = 4;

    localparam logic [KW_W-1:0] KW_A_RESET = 40'd1918986339;
    localparam logic [KW_W-1:0] KW_B_RESET = 40'd7630441;
    localparam logic [KW_W-1:0] KW_C_RESET = 40'd435610544247;
    localparam logic [KW_W-1:0] KW_D_RESET = 40'd1836412517;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    typedef enum logic [1:0] {
        CFG_KEYWORD_A = 2'd0,
        CFG_KEYWORD_B = 2'd1,
        CFG_KEYWORD_C = 2'd2,
        CFG_KEYWORD_D = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        CLS_CODE    = 3'd0,
        CLS_KEYWORD = 3'd1,
        CLS_LINE    = 3'd2,
        CLS_STRING  = 3'd3,
        CLS_CHAR    = 3'd4
    } class_t;

    typedef enum logic [3:0] {
        MODE_CODE       = 4'd0,
        MODE_SLASH      = 4'd1,
        MODE_BLOCK      = 4'd2,
        MODE_BLOCK_STAR = 4'd3,
        MODE_LINE       = 4'd4,
        MODE_STR        = 4'd5,
        MODE_STR_ESC    = 4'd6,
        MODE_CHR        = 4'd7,
        MODE_CHR_ESC    = 4'd8
    } mode_t;

    // Emission command for one accepted byte. Results go out in this order:
    // held slash, buffered word bytes, tail byte, second comment slash.
    typedef struct packed {
        logic                        pre_slash;
        logic [KEYWORD_LEN-1:0][7:0] word_bytes;
        logic [CNT_W-1:0]            word_len;
        class_t                      word_class;
        logic                        tail_valid;
        logic [7:0]                  tail_byte;
        class_t                      tail_class;
        logic                        dbl_slash;
    } cmd_t;

    function automatic logic is_ident(input logic [7:0] b);
        is_ident = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
                   (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F);
    endfunction

endpackage

// ===== hdl/chl_front.sv =====
// Front end of the lexer: lexical mode machine, word buffer and keyword match.
// Turns each accepted byte into at most one emission command; uses chl_pkg.
module chl_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [chl_pkg::KW_W-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    input  logic                      stream_last,
    input  logic                      q_full,
    output logic                      q_push,
    output chl_pkg::cmd_t             q_cmd
);
    import chl_pkg::*;

    mode_t                       mode_reg, mode_next;
    logic [KEYWORD_LEN-1:0][7:0] word_reg, word_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        too_long_reg, too_long_next;
    logic [KW_W-1:0]             kw_reg [NUM_KW];

    logic                        accept;
    logic                        cb_active;
    logic                        id_byte;
    logic                        append;
    logic [KEYWORD_LEN-1:0][7:0] aug_word;
    logic [CNT_W-1:0]            aug_count;
    logic [CMP_W-1:0]            cmp_vec;
    logic                        kw_hit;
    cmd_t                        cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Word as it stands once this byte has been appended, if it is.
    always_comb
    begin
        cb_active = (mode_reg == MODE_CODE) ||
                    ((mode_reg == MODE_SLASH) && (in_byte != CH_STAR) &&
                     (in_byte != CH_SLASH));
        id_byte   = is_ident(in_byte);
        append    = cb_active && id_byte && !too_long_reg &&
                    (count_reg < CNT_W'(KEYWORD_LEN));
        aug_word  = word_reg;
        aug_count = count_reg;
        if (append)
        begin
            aug_word[count_reg[IDX_W-1:0]] = in_byte;
            aug_count = count_reg + CNT_W'(1);
        end
    end

    // Whole-word match; bytes past the count are treated as zero padding.
    always_comb
    begin
        cmp_vec = '0;
        for (int i = 0; i < KEYWORD_LEN; i++)
        begin
            if (CNT_W'(i) < aug_count)
            begin
                cmp_vec[8*i +: 8] = aug_word[i];
            end
        end
        kw_hit = 1'b0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (cmp_vec == CMP_W'(kw_reg[k]))
            begin
                kw_hit = 1'b1;
            end
        end
        kw_hit = kw_hit && (aug_count != '0) && !too_long_reg;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        word_next      = aug_word;
        count_next     = aug_count;
        too_long_next  = too_long_reg;
        cmd.pre_slash  = 1'b0;
        cmd.word_bytes = word_reg;
        cmd.word_len   = '0;
        cmd.word_class = CLS_CODE;
        cmd.tail_valid = 1'b0;
        cmd.tail_byte  = in_byte;
        cmd.tail_class = CLS_CODE;
        cmd.dbl_slash  = 1'b0;

        unique case (mode_reg)
            MODE_CODE:
            begin
                mode_next = MODE_CODE;
            end
            MODE_SLASH:
            begin
                if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
                else if (in_byte == CH_SLASH)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_byte  = CH_SLASH;
                    cmd.tail_class = CLS_LINE;
                    cmd.dbl_slash  = 1'b1;
                    mode_next      = MODE_LINE;
                end
                else
                begin
                    cmd.pre_slash = 1'b1;
                    mode_next     = MODE_CODE;
                end
            end
            MODE_BLOCK:
            begin
                if (in_byte == CH_STAR)
                begin
                    mode_next = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR:
            begin
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_CODE;
                end
                else if (in_byte != CH_STAR)
                begin
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_LINE:
            begin
                cmd.tail_valid = 1'b1;
                if (in_byte == CH_NL)
                begin
                    cmd.tail_class = CLS_CODE;
                    mode_next      = MODE_CODE;
                end
                else
                begin
                    cmd.tail_class = CLS_LINE;
                end
            end
            MODE_STR:
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_class = CLS_STRING;
                if (in_byte == CH_DQUOTE)
                begin
                    mode_next = MODE_CODE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_STR_ESC;
                end
            end
            MODE_STR_ESC:
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_class = CLS_STRING;
                mode_next      = MODE_STR;
            end
            MODE_CHR:
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_class = CLS_CHAR;
                if (in_byte == CH_SQUOTE)
                begin
                    mode_next = MODE_CODE;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_CHR_ESC;
                end
            end
            MODE_CHR_ESC:
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_class = CLS_CHAR;
                mode_next      = MODE_CHR;
            end
            default:
            begin
                mode_next = MODE_CODE;
            end
        endcase

        // Plain code handling, also reached after a released slash.
        if (cb_active)
        begin
            if (id_byte)
            begin
                if (too_long_reg)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_class = CLS_CODE;
                end
                else if (!append)
                begin
                    // Word outgrew the buffer: release it and pass the rest as code.
                    cmd.word_len   = count_reg;
                    cmd.word_class = CLS_CODE;
                    count_next     = '0;
                    too_long_next  = 1'b1;
                    cmd.tail_valid = 1'b1;
                    cmd.tail_class = CLS_CODE;
                end
            end
            else
            begin
                cmd.word_len   = count_reg;
                cmd.word_class = kw_hit ? CLS_KEYWORD : CLS_CODE;
                count_next     = '0;
                too_long_next  = 1'b0;
                if (in_byte == CH_SLASH)
                begin
                    mode_next = MODE_SLASH;
                end
                else if (in_byte == CH_DQUOTE)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_class = CLS_STRING;
                    mode_next      = MODE_STR;
                end
                else if (in_byte == CH_SQUOTE)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_class = CLS_CHAR;
                    mode_next      = MODE_CHR;
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_class = CLS_CODE;
                end
            end
        end

        // End of stream flushes the word and a held slash, then resets.
        if (stream_last)
        begin
            if (count_next != '0)
            begin
                cmd.word_bytes = word_next;
                cmd.word_len   = count_next;
                cmd.word_class = kw_hit ? CLS_KEYWORD : CLS_CODE;
            end
            if (mode_next == MODE_SLASH)
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_byte  = CH_SLASH;
                cmd.tail_class = CLS_CODE;
            end
            mode_next     = MODE_CODE;
            count_next    = '0;
            too_long_next = 1'b0;
        end
    end

    assign q_cmd  = cmd;
    assign q_push = accept &&
                    (cmd.pre_slash || (cmd.word_len != '0) || cmd.tail_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_CODE;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg[0] <= KW_A_RESET;
            kw_reg[1] <= KW_B_RESET;
            kw_reg[2] <= KW_C_RESET;
            kw_reg[3] <= KW_D_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KEYWORD_A: kw_reg[0] <= cfg_data;
                CFG_KEYWORD_B: kw_reg[1] <= cfg_data;
                CFG_KEYWORD_C: kw_reg[2] <= cfg_data;
                CFG_KEYWORD_D: kw_reg[3] <= cfg_data;
                default:       kw_reg[0] <= kw_reg[0];
            endcase
        end
    end

endmodule

// ===== hdl/chl_queue.sv =====
// Command queue between the lexer front end and the emitter.
// Small register FIFO of chl_pkg::cmd_t entries; uses chl_pkg.
module chl_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  chl_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output chl_pkg::cmd_t head_cmd
);
    import chl_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/chl_back.sv =====
// Emitter: expands one queued command into tagged result bytes, one per cycle unless out_stall holds it.
// Holds the output register of the result channel; uses chl_pkg.
module chl_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  chl_pkg::cmd_t q_cmd,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic [2:0]    char_class,
    output logic          run_end
);
    import chl_pkg::*;

    cmd_t             cur_reg;
    logic             pre_pend_reg, pre_pend_next;
    logic [CNT_W-1:0] widx_reg, widx_next;
    logic [CNT_W-1:0] wlen_reg, wlen_next;
    logic             tail_pend_reg, tail_pend_next;
    logic             dbl_pend_reg, dbl_pend_next;

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    class_t           out_class_reg, out_class_next;
    logic             out_end_reg, out_end_next;

    logic             word_pend;
    logic             have_work;
    logic             out_ready;
    logic             emit;
    logic [7:0]       sel_byte;
    class_t           sel_class;
    logic             sel_last;
    logic             finishing;

    assign word_pend = (widx_reg < wlen_reg);
    assign have_work = pre_pend_reg || word_pend || tail_pend_reg || dbl_pend_reg;
    assign out_ready = !out_valid_reg || !out_stall;
    assign emit      = have_work && out_ready;

    // Pick the first pending result in command order.
    always_comb
    begin
        sel_byte  = CH_SLASH;
        sel_class = CLS_CODE;
        sel_last  = 1'b1;
        if (pre_pend_reg)
        begin
            sel_last = word_pend || tail_pend_reg || dbl_pend_reg;
            sel_last = !sel_last;
        end
        else if (word_pend)
        begin
            sel_byte  = cur_reg.word_bytes[widx_reg[IDX_W-1:0]];
            sel_class = cur_reg.word_class;
            sel_last  = !(((widx_reg + CNT_W'(1)) < wlen_reg) ||
                          tail_pend_reg || dbl_pend_reg);
        end
        else if (tail_pend_reg)
        begin
            sel_byte  = cur_reg.tail_byte;
            sel_class = cur_reg.tail_class;
            sel_last  = !dbl_pend_reg;
        end
        else
        begin
            sel_class = CLS_LINE;
        end
    end

    // A new command loads as soon as the current one hands out its last byte.
    assign finishing = !have_work || (emit && sel_last);
    assign q_pop     = finishing && q_valid;

    always_comb
    begin
        pre_pend_next  = pre_pend_reg;
        widx_next      = widx_reg;
        wlen_next      = wlen_reg;
        tail_pend_next = tail_pend_reg;
        dbl_pend_next  = dbl_pend_reg;
        if (q_pop)
        begin
            pre_pend_next  = q_cmd.pre_slash;
            widx_next      = '0;
            wlen_next      = q_cmd.word_len;
            tail_pend_next = q_cmd.tail_valid;
            dbl_pend_next  = q_cmd.dbl_slash;
        end
        else if (emit)
        begin
            if (pre_pend_reg)
            begin
                pre_pend_next = 1'b0;
            end
            else if (word_pend)
            begin
                widx_next = widx_reg + CNT_W'(1);
            end
            else if (tail_pend_reg)
            begin
                tail_pend_next = 1'b0;
            end
            else
            begin
                dbl_pend_next = 1'b0;
            end
        end

        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_class_next = out_class_reg;
        out_end_next   = out_end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = sel_byte;
            out_class_next = sel_class;
            out_end_next   = sel_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_pend_reg  <= 1'b0;
            widx_reg      <= '0;
            wlen_reg      <= '0;
            tail_pend_reg <= 1'b0;
            dbl_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pre_pend_reg  <= pre_pend_next;
            widx_reg      <= widx_next;
            wlen_reg      <= wlen_next;
            tail_pend_reg <= tail_pend_next;
            dbl_pend_reg  <= dbl_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_cmd;
        end
        out_byte_reg  <= out_byte_next;
        out_class_reg <= out_class_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign char_class = out_class_reg;
    assign run_end    = out_end_reg;

    // The word pointer never runs past the buffered length.
    a_widx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        widx_reg <= wlen_reg)
        else $error("word index past word length");

    // The front end never queues a command that yields no result.
    a_loaded_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> have_work)
        else $error("empty command loaded");

    // After the last result of a command, nothing of it remains pending.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && sel_last && !q_valid) |=> !have_work)
        else $error("work left after final result");

endmodule

// ===== hdl/c_source_highlight_lexer_core.sv =====
// C source highlight lexer, top level: joins front end, command queue and emitter.
// Depends on chl_pkg, chl_front, chl_queue and chl_back.
//
// This block takes C source one byte per transaction and returns every byte that
// survives lexing as a transaction tagged with a class: code, keyword, line
// comment, string literal or char literal. Block comments are dropped whole, a
// slash is held until the next byte shows what it opens, and identifier bytes are
// buffered up to five characters and matched whole-word against the four keyword
// registers before they go out. run_end marks the last result an input byte
// causes; bytes that cause nothing produce no transaction. The front end takes
// one input byte per cycle as long as its four-entry command queue has room, and
// the emitter hands out one result per cycle unless out_stall holds it; an
// input byte yields zero to six results, one on average for plain text;
// sustained throughput is set by the emitter's single output port, with word
// flushes absorbed by the queue. Keyword registers may only be written while the
// block holds no undelivered results.
module c_source_highlight_lexer_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [chl_pkg::KW_W-1:0] cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               in_byte,
    input  logic                     stream_last,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               out_byte,
    output logic [2:0]               char_class,
    output logic                     run_end
);
    import chl_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t push_cmd;
    logic q_pop;
    logic q_valid;
    cmd_t head_cmd;

    // Lexer state, word buffer and keyword compare.
    chl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .stream_last (stream_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // Decouples the input rate from bursts of word flushes on the output.
    chl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    // Serializes each command into tagged bytes behind an output register.
    chl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_cmd      (head_cmd),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .char_class (char_class),
        .run_end    (run_end)
    );

endmodule

// ===== test/c_source_highlight_lexer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for c_source_highlight_lexer_core: directed and random C text.
// Depends on chl_pkg and the lexer RTL; needs no files or arguments at run time.
module c_source_highlight_lexer_core_tb;

    import chl_pkg::*;

    // The run is stopped here whatever happens; a correct run needs far fewer cycles.
    localparam int CYCLE_LIMIT   = 300000;
    // Cycles allowed after the last expected byte for work that emits nothing.
    localparam int SETTLE_CYCLES = 16;
    // Counted input transactions per random phase.
    localparam int PHASE_ITEMS   = 84;

    // One expected output transaction.
    typedef struct {
        logic [7:0] ch;
        class_t     cls;
        logic       fin;
    } classed_byte_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [1:0]       cfg_index;
    logic [KW_W-1:0]  cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       in_byte;
    logic             stream_last;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic [2:0]       char_class;
    logic             run_end;

    // Lexer state as the testbench sees it. It follows every accepted byte.
    mode_t            lex_st;
    logic [7:0]       word_buf [KEYWORD_LEN];
    int unsigned      word_len;
    bit               word_long;
    logic [KW_W-1:0]  kw_table [NUM_KW];

    classed_byte_t    pending_bytes [$];
    classed_byte_t    step_out [$];

    int               fail_count;
    int               cycle_count;
    int               live_items;
    int               send_idle_pct;
    int               stall_pct;

    // Words the random text draws on: the keywords of every setting used below,
    // plus near misses that differ by one character or by length.
    string vocab [16] = '{"char", "int", "while", "enum", "for", "do", "break", "a",
                          "Zz_09", "if", "q_1", "chars", "in", "whiles", "integer", "x9"};

    c_source_highlight_lexer_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .stream_last (stream_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .char_class  (char_class),
        .run_end     (run_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Prediction of the classified byte stream.
    // ------------------------------------------------------------------

    function automatic void put(input logic [7:0] b, input class_t c);
        classed_byte_t e;
        e.ch  = b;
        e.cls = c;
        e.fin = 1'b0;
        step_out.push_back(e);
    endfunction

    function automatic bit is_word_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || (b == "_");
    endfunction

    // Release the buffered identifier bytes under one class and empty the buffer.
    function automatic void release_word(input class_t c);
        for (int i = 0; i < word_len; i++)
            put(word_buf[i], c);
        word_len = 0;
    endfunction

    // A word boundary: the whole buffered word is a keyword only if it fits and
    // equals one register exactly, zero padding included.
    function automatic void close_word();
        class_t          c;
        logic [KW_W-1:0] packed_word;
        c = CLS_CODE;
        if (word_len != 0 && !word_long)
        begin
            packed_word = '0;
            for (int i = 0; i < word_len; i++)
                packed_word[8*i +: 8] = word_buf[i];
            for (int k = 0; k < NUM_KW; k++)
                if (packed_word == kw_table[k])
                    c = CLS_KEYWORD;
        end
        release_word(c);
        word_long = 1'b0;
    endfunction

    function automatic void code_char(input logic [7:0] b);
        if (is_word_char(b))
        begin
            if (word_long)
                put(b, CLS_CODE);
            else if (word_len < KEYWORD_LEN)
            begin
                word_buf[word_len] = b;
                word_len++;
            end
            else
            begin
                // The word outgrew every keyword: it is plain code from here on.
                release_word(CLS_CODE);
                word_long = 1'b1;
                put(b, CLS_CODE);
            end
            return;
        end
        close_word();
        if (b == CH_SLASH)
            lex_st = MODE_SLASH;
        else if (b == CH_DQUOTE)
        begin
            put(b, CLS_STRING);
            lex_st = MODE_STR;
        end
        else if (b == CH_SQUOTE)
        begin
            put(b, CLS_CHAR);
            lex_st = MODE_CHR;
        end
        else
            put(b, CLS_CODE);
    endfunction

    // Work out the results of one input byte and queue them in order, with the
    // end-of-run flag on the last one.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        classed_byte_t e;
        step_out.delete();
        case (lex_st)
            MODE_CODE:
                code_char(b);
            MODE_SLASH:
                if (b == CH_STAR)
                    lex_st = MODE_BLOCK;
                else if (b == CH_SLASH)
                begin
                    put(CH_SLASH, CLS_LINE);
                    put(CH_SLASH, CLS_LINE);
                    lex_st = MODE_LINE;
                end
                else
                begin
                    put(CH_SLASH, CLS_CODE);
                    lex_st = MODE_CODE;
                    code_char(b);
                end
            MODE_BLOCK:
                if (b == CH_STAR)
                    lex_st = MODE_BLOCK_STAR;
            MODE_BLOCK_STAR:
                if (b == CH_SLASH)
                    lex_st = MODE_CODE;
                else if (b != CH_STAR)
                    lex_st = MODE_BLOCK;
            MODE_LINE:
                if (b == CH_NL)
                begin
                    put(b, CLS_CODE);
                    lex_st = MODE_CODE;
                end
                else
                    put(b, CLS_LINE);
            MODE_STR:
            begin
                put(b, CLS_STRING);
                if (b == CH_DQUOTE)
                    lex_st = MODE_CODE;
                else if (b == CH_BSLASH)
                    lex_st = MODE_STR_ESC;
            end
            MODE_STR_ESC:
            begin
                put(b, CLS_STRING);
                lex_st = MODE_STR;
            end
            MODE_CHR:
            begin
                put(b, CLS_CHAR);
                if (b == CH_SQUOTE)
                    lex_st = MODE_CODE;
                else if (b == CH_BSLASH)
                    lex_st = MODE_CHR_ESC;
            end
            MODE_CHR_ESC:
            begin
                put(b, CLS_CHAR);
                lex_st = MODE_CHR;
            end
            default:
                lex_st = MODE_CODE;
        endcase

        // End of stream: flush the word, release a held slash, and forget any
        // open comment or literal.
        if (last)
        begin
            close_word();
            if (lex_st == MODE_SLASH)
                put(CH_SLASH, CLS_CODE);
            lex_st    = MODE_CODE;
            word_len  = 0;
            word_long = 1'b0;
        end

        for (int i = 0; i < step_out.size(); i++)
        begin
            e     = step_out[i];
            e.fin = (i == step_out.size() - 1);
            pending_bytes.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Send one byte transaction. The prediction is made before valid goes up;
    // items are accepted strictly in order, so it cannot run ahead of the block
    // in any way that matters.
    task automatic send_byte(input logic [7:0] b, input logic last);
        // Bytes swallowed inside a block comment do not count toward a phase.
        if (!(lex_st inside {MODE_BLOCK, MODE_BLOCK_STAR}))
            live_items++;
        predict_byte(b, last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= b;
        stream_last <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input bit last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last && (i == s.len() - 1));
    endtask

    // Stop sending and wait until every expected byte has come out, then give
    // the block time to finish any byte that emits nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write enable stays high across back-to-back writes; the caller lowers it.
    task automatic write_reg(input cfg_index_t idx, input logic [KW_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        kw_table[idx] = v;
    endtask

    task automatic load_keywords(input logic [KW_W-1:0] a, input logic [KW_W-1:0] b,
                                 input logic [KW_W-1:0] c, input logic [KW_W-1:0] d);
        settle();
        write_reg(CFG_KEYWORD_A, a);
        write_reg(CFG_KEYWORD_B, b);
        write_reg(CFG_KEYWORD_C, c);
        write_reg(CFG_KEYWORD_D, d);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [KW_W-1:0] pack_word(input string s);
        logic [KW_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < KEYWORD_LEN; i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // Printable byte that does not end or escape a literal.
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(32, 126));
        if (b == CH_DQUOTE || b == CH_SQUOTE || b == CH_BSLASH)
            b = "z";
        return b;
    endfunction

    function automatic logic [7:0] ident_char();
        int unsigned r;
        r = $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + (r - 26));
        else if (r < 62)
            return 8'("0" + (r - 52));
        return "_";
    endfunction

    // One token of C-like text. Most tokens are well formed so that comments,
    // literals and keyword matching are reached; a share is raw noise.
    task automatic send_random_token();
        logic [7:0] tok [$];
        string      w;
        string      punct;
        int         n;
        bit         last;
        punct = " \n\t;(){}+-=*,<";
        last  = ($urandom_range(0, 11) == 0);
        case ($urandom_range(0, 9))
            0, 1:
            begin
                w = vocab[$urandom_range(0, 15)];
                for (int i = 0; i < w.len(); i++)
                    tok.push_back(w[i]);
                if ($urandom_range(0, 1))
                    tok.push_back(punct[$urandom_range(0, punct.len() - 1)]);
            end
            2:
            begin
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    tok.push_back(ident_char());
                if ($urandom_range(0, 1))
                    tok.push_back(" ");
            end
            3:
                tok.push_back(punct[$urandom_range(0, punct.len() - 1)]);
            4:
            begin
                tok.push_back(CH_DQUOTE);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        tok.push_back(CH_BSLASH);
                        tok.push_back(8'($urandom_range(0, 255)));
                    end
                    else
                        tok.push_back(plain_char());
                end
                tok.push_back(CH_DQUOTE);
            end
            5:
            begin
                tok.push_back(CH_SQUOTE);
                if ($urandom_range(0, 2) == 0)
                begin
                    tok.push_back(CH_BSLASH);
                    tok.push_back(8'($urandom_range(0, 255)));
                end
                else
                    tok.push_back(plain_char());
                tok.push_back(CH_SQUOTE);
            end
            6:
            begin
                tok.push_back(CH_SLASH);
                tok.push_back(CH_SLASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    tok.push_back(plain_char());
                tok.push_back(CH_NL);
            end
            7:
            begin
                // Block comment body mixes stars and slashes so that star runs
                // and early closes both happen.
                tok.push_back(CH_SLASH);
                tok.push_back(CH_STAR);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++)
                    case ($urandom_range(0, 3))
                        0: tok.push_back(CH_STAR);
                        1: tok.push_back(CH_SLASH);
                        2: tok.push_back(" ");
                        default: tok.push_back(8'($urandom_range(0, 255)));
                    endcase
                tok.push_back(CH_STAR);
                tok.push_back(CH_SLASH);
            end
            8:
            begin
                // Lone slash: division, or a slash right before a word.
                tok.push_back(CH_SLASH);
                tok.push_back($urandom_range(0, 1) ? " " : ident_char());
            end
            default:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            end
        endcase
        for (int i = 0; i < tok.size(); i++)
            send_byte(tok[i], last && (i == tok.size() - 1));
    endtask

    // ------------------------------------------------------------------
    // Output side: stall at random and check every result transaction.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        classed_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected result: out_byte %0h char_class %0d run_end %0b",
                       out_byte, char_class, run_end);
                fail_count++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.ch)
                begin
                    $error("out_byte: expected %0h, got %0h", want.ch, out_byte);
                    fail_count++;
                end
                if (char_class !== want.cls)
                begin
                    $error("char_class: expected %0d, got %0d", want.cls, char_class);
                    fail_count++;
                end
                if (run_end !== want.fin)
                begin
                    $error("run_end: expected %0b, got %0b", want.fin, run_end);
                    fail_count++;
                end
            end
        end
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A five-letter keyword closed by punctuation, and a three-letter one that
    // only the end of the stream closes.
    task automatic test_keywords();
        send_text("while(int", 1'b1);
    endtask

    // The sixth letter spills the whole buffer as code: six results from one byte.
    task automatic test_long_word();
        send_text("abcdef", 1'b1);
    endtask

    // A block comment closed by a run of stars, then an empty line comment whose
    // newline comes out as code.
    task automatic test_comments();
        send_text("/***/", 1'b0);
        send_text("//\n", 1'b0);
    endtask

    // Escaped quotes inside a string and a char literal, with the byte extremes
    // carried through the string.
    task automatic test_literals();
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_BSLASH, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
        send_byte(CH_SQUOTE, 1'b0);
    endtask

    // A slash used as division, then a slash held at the end of the stream.
    task automatic test_held_slash();
        send_text("a/b/", 1'b1);
    endtask

    // Random text under one idling setting; it closes the stream at the end so
    // the next phase starts from a clean lexer.
    task automatic test_random_text(input int idle_in, input int idle_out);
        int target;
        send_idle_pct = idle_in;
        stall_pct     = idle_out;
        target        = live_items + PHASE_ITEMS;
        while (live_items < target)
            send_random_token();
        send_byte(" ", 1'b1);
        settle();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_KEYWORD_A;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        stream_last   = 1'b0;
        fail_count    = 0;
        cycle_count   = 0;
        live_items    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        lex_st        = MODE_CODE;
        word_len      = 0;
        word_long     = 1'b0;
        kw_table[0]   = KW_A_RESET;
        kw_table[1]   = KW_B_RESET;
        kw_table[2]   = KW_C_RESET;
        kw_table[3]   = KW_D_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed checks run on the keywords the block comes out of reset with.
        test_keywords();
        test_long_word();
        test_comments();
        test_literals();
        test_held_slash();
        test_random_text(0, 0);

        // The all-ones register can never match; a five-letter keyword can.
        load_keywords(pack_word("for"), pack_word("do"), pack_word("break"), '1);
        test_random_text(80, 0);

        // The all-zero register can never match a non-empty word.
        load_keywords('0, pack_word("a"), pack_word("Zz_09"), pack_word("if"));
        test_random_text(0, 80);

        load_keywords(pack_word("q_1"), pack_word("int"), pack_word("chars"),
                      pack_word("enum"));
        test_random_text(37, 37);

        settle();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
